FILE: rtl/core/shbs_pkg.sv
// ----------------------------------------------------------------------------
// shbs_pkg
// Shared types, constants and round functions for the SHA-256 byte hasher.
// ----------------------------------------------------------------------------
package shbs_pkg;

  localparam int unsigned HASH_WORDS = 8;

  typedef logic [31:0] word_t;
  typedef logic [0:HASH_WORDS-1][31:0] hash_t;

  // item kinds
  localparam logic KIND_ABSORB = 1'b0;
  localparam logic KIND_FINISH = 1'b1;

  localparam logic [7:0]  PAD_BYTE   = 8'h80;
  localparam logic [7:0]  ZERO_BYTE  = 8'h00;
  localparam logic [6:0]  LEN_START  = 7'd56;
  localparam logic [6:0]  FULL_COUNT = 7'd64;
  localparam logic [63:0] BLOCK_BITS = 64'd512;
  localparam logic [5:0]  LAST_ROUND = 6'd63;
  localparam logic [2:0]  LAST_INDEX = 3'd7;

  localparam hash_t INIT_H = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [0:63][31:0] ROUND_K = {
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COMP,
    ST_FINAL,
    ST_PAD,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  typedef struct packed {
    logic       load;
    logic [7:0] data;
    logic       step;
  } sched_ctl_t;

  typedef struct packed {
    logic       init;
    logic       step;
    logic [5:0] round;
  } round_ctl_t;

  function automatic word_t big_sigma0(word_t x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic word_t big_sigma1(word_t x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic word_t small_sigma0(word_t x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ (x >> 3);
  endfunction

  function automatic word_t small_sigma1(word_t x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ (x >> 10);
  endfunction

endpackage

FILE: rtl/core/shbs_sched.sv
// ----------------------------------------------------------------------------
// shbs_sched
// Block buffer and message schedule window: bytes shift in at the bottom,
// and during rounds the window shifts one word up and appends W[t+16].
// ----------------------------------------------------------------------------
module shbs_sched (
  input  logic                   clk,
  input  shbs_pkg::sched_ctl_t   ctl,
  output shbs_pkg::word_t        w_cur
);

  // word i of the window sits at win[511-32*i -: 32]
  logic [511:0]    win;
  logic [511:0]    win_next;
  shbs_pkg::word_t w_new;

  assign w_cur = win[511:480];

  always_comb begin
    w_new = shbs_pkg::small_sigma1(win[63:32]) + win[223:192]
          + shbs_pkg::small_sigma0(win[479:448]) + win[511:480];
  end

  always_comb begin
    priority if (ctl.load) begin
      win_next = {win[503:0], ctl.data};
    end else if (ctl.step) begin
      win_next = {win[479:0], w_new};
    end else begin
      win_next = win;
    end
  end

  always_ff @(posedge clk) begin
    win <= win_next;
  end

endmodule

FILE: rtl/core/shbs_round.sv
// ----------------------------------------------------------------------------
// shbs_round
// Working variables a..h and the single compression round unit.
// ----------------------------------------------------------------------------
module shbs_round (
  input  logic                   clk,
  input  shbs_pkg::round_ctl_t   ctl,
  input  shbs_pkg::hash_t        hash_in,
  input  shbs_pkg::word_t        w_cur,
  output shbs_pkg::hash_t        work
);

  shbs_pkg::word_t a, b, c, d, e, f, g, h;
  shbs_pkg::word_t t1, t2;

  assign {a, b, c, d, e, f, g, h} = work;

  always_comb begin
    t1 = h + shbs_pkg::big_sigma1(e) + ((e & f) ^ (~e & g))
       + shbs_pkg::ROUND_K[ctl.round] + w_cur;
    t2 = shbs_pkg::big_sigma0(a) + ((a & b) ^ (a & c) ^ (b & c));
  end

  always_ff @(posedge clk) begin
    if (ctl.init) begin
      work <= hash_in;
    end else if (ctl.step) begin
      work <= {t1 + t2, a, b, c, d + t1, e, f, g};
    end
  end

endmodule

FILE: rtl/core/sha256_byte_stream_hasher.sv
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher
// SHA-256 over a byte stream, one byte per item; a finish item pads the
// message and returns the eight digest words.
// ----------------------------------------------------------------------------
// The byte that completes a 64-byte block starts a compression: the rounds
// in ST_COMP, then the hash update in ST_FINAL, with item_ready low
// throughout. A finish item pads one byte per cycle (0x80, zeros, then the
// 64-bit length), runs one compression, or two when 56 or more bytes were
// pending, then offers the eight digest words, word 0 first, one per cycle
// as digest_ready allows. The pace is set by the one round unit, which does
// one SHA-256 round per cycle. After the last word the hasher is back at the
// initial hash values.
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_ready,
  input  shbs_pkg::in_item_t    item,
  output logic                  digest_valid,
  input  logic                  digest_ready,
  output shbs_pkg::out_item_t   digest
);

  shbs_pkg::state_t     state;
  shbs_pkg::state_t     state_next;
  logic [6:0]           byte_count;
  logic [63:0]          total_bits;
  logic [63:0]          len_bits;
  shbs_pkg::hash_t      hv;
  shbs_pkg::hash_t      work;
  logic [5:0]           round;
  logic [2:0]           widx;
  logic                 fin;
  logic                 need_extra;
  logic                 last_blk;
  logic                 accept;
  logic                 pad_zero;
  shbs_pkg::sched_ctl_t sched_ctl;
  shbs_pkg::round_ctl_t round_ctl;
  shbs_pkg::word_t      w_cur;

  assign accept   = item_valid & item_ready;
  // zero fill until the length field of the final block
  assign pad_zero = need_extra || (byte_count < shbs_pkg::LEN_START);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      shbs_pkg::ST_IDLE: begin
        if (accept) begin
          if (item.kind == shbs_pkg::KIND_FINISH) begin
            state_next = shbs_pkg::ST_PAD;
          end else if (byte_count == shbs_pkg::FULL_COUNT - 7'd1) begin
            state_next = shbs_pkg::ST_COMP;
          end
        end
      end
      shbs_pkg::ST_COMP: begin
        if (round == shbs_pkg::LAST_ROUND) begin
          state_next = shbs_pkg::ST_FINAL;
        end
      end
      shbs_pkg::ST_FINAL: begin
        if (!fin) begin
          state_next = shbs_pkg::ST_IDLE;
        end else if (last_blk) begin
          state_next = shbs_pkg::ST_EMIT;
        end else begin
          state_next = shbs_pkg::ST_PAD;
        end
      end
      shbs_pkg::ST_PAD: begin
        if (byte_count == shbs_pkg::FULL_COUNT) begin
          state_next = shbs_pkg::ST_COMP;
        end
      end
      shbs_pkg::ST_EMIT: begin
        if (digest_ready && widx == shbs_pkg::LAST_INDEX) begin
          state_next = shbs_pkg::ST_IDLE;
        end
      end
      default: state_next = shbs_pkg::ST_IDLE;
    endcase
  end

  // outputs and unit controls
  always_comb begin
    item_ready       = (state == shbs_pkg::ST_IDLE);
    digest_valid     = (state == shbs_pkg::ST_EMIT);
    sched_ctl.load   = 1'b0;
    sched_ctl.data   = item.data_byte;
    sched_ctl.step   = (state == shbs_pkg::ST_COMP);
    round_ctl.init   = (state != shbs_pkg::ST_COMP) && (state_next == shbs_pkg::ST_COMP);
    round_ctl.step   = (state == shbs_pkg::ST_COMP);
    round_ctl.round  = round;
    unique case (state)
      shbs_pkg::ST_IDLE: begin
        sched_ctl.load = accept;
        if (item.kind == shbs_pkg::KIND_FINISH) begin
          sched_ctl.data = shbs_pkg::PAD_BYTE;
        end
      end
      shbs_pkg::ST_PAD: begin
        sched_ctl.load = (byte_count != shbs_pkg::FULL_COUNT);
        sched_ctl.data = pad_zero ? shbs_pkg::ZERO_BYTE : len_bits[63:56];
      end
      shbs_pkg::ST_COMP, shbs_pkg::ST_FINAL, shbs_pkg::ST_EMIT: begin
      end
      default: begin
      end
    endcase
  end

  assign digest.digest_word = hv[widx];
  assign digest.word_index  = widx;
  assign digest.last_word   = (widx == shbs_pkg::LAST_INDEX);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= shbs_pkg::ST_IDLE;
      byte_count <= '0;
      total_bits <= '0;
      hv         <= shbs_pkg::INIT_H;
      round      <= '0;
      widx       <= '0;
      fin        <= 1'b0;
      need_extra <= 1'b0;
      last_blk   <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        shbs_pkg::ST_IDLE: begin
          if (accept) begin
            byte_count <= byte_count + 7'd1;
            if (item.kind == shbs_pkg::KIND_FINISH) begin
              fin        <= 1'b1;
              need_extra <= (byte_count >= shbs_pkg::LEN_START);
              len_bits   <= total_bits + {55'd0, byte_count[5:0], 3'd0};
            end
          end
        end
        shbs_pkg::ST_COMP: begin
          round <= round + 6'd1;
        end
        shbs_pkg::ST_FINAL: begin
          for (int i = 0; i < shbs_pkg::HASH_WORDS; i++) begin
            hv[i] <= hv[i] + work[i];
          end
          total_bits <= total_bits + shbs_pkg::BLOCK_BITS;
          byte_count <= '0;
        end
        shbs_pkg::ST_PAD: begin
          if (byte_count == shbs_pkg::FULL_COUNT) begin
            last_blk   <= !need_extra;
            need_extra <= 1'b0;
          end else begin
            byte_count <= byte_count + 7'd1;
            if (!pad_zero) begin
              len_bits <= {len_bits[55:0], 8'd0};
            end
          end
        end
        shbs_pkg::ST_EMIT: begin
          if (digest_ready) begin
            widx <= widx + 3'd1;
            if (widx == shbs_pkg::LAST_INDEX) begin
              hv         <= shbs_pkg::INIT_H;
              byte_count <= '0;
              total_bits <= '0;
              fin        <= 1'b0;
              last_blk   <= 1'b0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  shbs_sched u_sched (
    .clk   (clk),
    .ctl   (sched_ctl),
    .w_cur (w_cur)
  );

  shbs_round u_round (
    .clk     (clk),
    .ctl     (round_ctl),
    .hash_in (hv),
    .w_cur   (w_cur),
    .work    (work)
  );

  // a full buffer is always compressed before the next item is taken
  a_ready_not_full: assert property (@(posedge clk) disable iff (rst)
    item_ready |-> byte_count < shbs_pkg::FULL_COUNT)
    else $error("item taken with a full block buffer");

  a_comp_full: assert property (@(posedge clk) disable iff (rst)
    state == shbs_pkg::ST_COMP |-> byte_count == shbs_pkg::FULL_COUNT)
    else $error("compression on a partial block");

  a_comp_runs: assert property (@(posedge clk) disable iff (rst)
    (state == shbs_pkg::ST_COMP && round != shbs_pkg::LAST_ROUND)
      |=> state == shbs_pkg::ST_COMP)
    else $error("compression cut short");

  a_first_word: assert property (@(posedge clk) disable iff (rst)
    $rose(digest_valid) |-> widx == 3'd0)
    else $error("digest does not start at word 0");

  a_restart: assert property (@(posedge clk) disable iff (rst)
    (digest_valid && digest_ready && digest.last_word)
      |=> (item_ready && byte_count == 7'd0 && total_bits == 64'd0))
    else $error("state not cleared after digest");

endmodule
